// ===== sv/plar_pkg.sv =====
// shared constants and types for the polyline arc-length point block
package plar_pkg;

  localparam int MAX_POINTS   = 64;
  localparam int DIM          = 6;
  localparam int COORD_FIELDS = 6;

  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int PIDX_W  = $clog2(MAX_POINTS);
  localparam int PADDR_W = $clog2(MAX_POINTS * DIM);
  localparam int J_W     = $clog2(COORD_FIELDS);

  localparam int COORD_W = 32;
  localparam int LEN_W   = 40;
  localparam int SQ_W    = 64;
  localparam int ACC_W   = 67;
  localparam int RAD_W   = 68;
  localparam int ROOT_W  = 34;
  localparam int PROD_W  = 72;
  localparam int QUO_W   = 34;
  localparam int HALF_W  = 20;
  localparam int FRAC_W  = 18;
  localparam int ONE_Q16 = 65536;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

endpackage

// ===== sv/polyline_arc_length_point.sv =====
// top level of the polyline arc-length point block
// Holds a path of up to 64 points of six Q16.16 coordinates in a point ram and
// the segment lengths in a second ram, and serves one request at a time. A clear
// or an ignored request goes straight to the output stage; an append reads,
// differences, squares and accumulates each coordinate, then takes the square
// root for the closing segment; a query scales the fraction, walks the segments
// through the length ram, then for each coordinate does two point reads, a
// difference, a multiply and a divide, or reads the coordinate where an end
// point is returned. A new request is taken as soon as the sequencer is back in
// idle, while the previous result may still sit in the output register.
module polyline_arc_length_point (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] in_coord_0,
  input  logic signed [31:0] in_coord_1,
  input  logic signed [31:0] in_coord_2,
  input  logic signed [31:0] in_coord_3,
  input  logic signed [31:0] in_coord_4,
  input  logic signed [31:0] in_coord_5,
  input  logic signed [17:0] fraction,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_coord_0,
  output logic signed [31:0] out_coord_1,
  output logic signed [31:0] out_coord_2,
  output logic signed [31:0] out_coord_3,
  output logic signed [31:0] out_coord_4,
  output logic signed [31:0] out_coord_5,
  output logic [1:0]         status,
  output logic [6:0]         stored_points
);

  localparam int NF = plar_pkg::COORD_FIELDS;
  localparam logic signed [17:0] FRAC_ONE = 18'(plar_pkg::ONE_Q16);

  typedef enum logic [18:0] {
    S_IDLE     = 19'b0000000000000000001,
    S_APP_RD   = 19'b0000000000000000010,
    S_APP_DIFF = 19'b0000000000000000100,
    S_APP_SQ   = 19'b0000000000000001000,
    S_APP_ACC  = 19'b0000000000000010000,
    S_APP_SQRT = 19'b0000000000000100000,
    S_APP_END  = 19'b0000000000001000000,
    S_EMIT_RD  = 19'b0000000000010000000,
    S_EMIT_CAP = 19'b0000000000100000000,
    S_Q_POS    = 19'b0000000001000000000,
    S_Q_RD     = 19'b0000000010000000000,
    S_Q_CMP    = 19'b0000000100000000000,
    S_I_RDA    = 19'b0000001000000000000,
    S_I_RDB    = 19'b0000010000000000000,
    S_I_V      = 19'b0000100000000000000,
    S_I_M1     = 19'b0001000000000000000,
    S_I_M2     = 19'b0010000000000000000,
    S_I_DIV    = 19'b0100000000000000000,
    S_DONE     = 19'b1000000000000000000
  } state_t;

  state_t state;

  logic [plar_pkg::CNT_W-1:0]   count;
  logic [plar_pkg::LEN_W-1:0]   total;
  logic [plar_pkg::COORD_W-1:0] cin [NF];
  logic [16:0]                  frac;
  logic [plar_pkg::J_W-1:0]     j;
  logic [plar_pkg::PIDX_W-1:0]  pidx;
  logic [plar_pkg::PIDX_W-1:0]  s;
  logic [plar_pkg::LEN_W-1:0]   pos;
  logic [plar_pkg::LEN_W-1:0]   seg_dist;
  logic [plar_pkg::ACC_W-1:0]   acc;
  logic [plar_pkg::ACC_W-1:0]   acc_sum;
  logic [plar_pkg::COORD_W-1:0] absd;
  logic [plar_pkg::SQ_W-1:0]    sq;
  logic [plar_pkg::COORD_W-1:0] a_val;
  logic                         neg;
  logic [plar_pkg::HALF_W+plar_pkg::COORD_W-1:0] plo;
  logic [plar_pkg::HALF_W+plar_pkg::COORD_W-1:0] phi;
  logic [plar_pkg::COORD_W-1:0] res [NF];
  logic [1:0]                   res_status;
  logic [plar_pkg::COORD_W-1:0] oc [NF];

  // ram ports
  logic                          pt_we;
  logic [plar_pkg::PADDR_W-1:0]  pt_waddr;
  logic [plar_pkg::PADDR_W-1:0]  pt_raddr;
  logic [plar_pkg::COORD_W-1:0]  pt_rdata;
  logic [plar_pkg::PIDX_W-1:0]   rd_pidx;
  logic                          seg_we;
  logic [plar_pkg::LEN_W-1:0]    seg_rdata;

  logic                          sqrt_start;
  logic                          sqrt_done;
  logic [plar_pkg::ROOT_W-1:0]   sqrt_root;
  logic                          div_start;
  logic                          div_done;
  logic [plar_pkg::QUO_W-1:0]    div_q;
  logic [plar_pkg::PROD_W-1:0]   div_dividend;

  logic                          accept;
  logic                          last_j;
  logic signed [plar_pkg::COORD_W:0] diff;
  logic [56:0]                   pos_prod;
  logic [plar_pkg::LEN_W:0]      tot_sum;
  logic [plar_pkg::COORD_W-1:0]  q32;

  function automatic logic [plar_pkg::PADDR_W-1:0] paddr(
    input logic [plar_pkg::PIDX_W-1:0] p,
    input logic [plar_pkg::J_W-1:0]    jj
  );
    return plar_pkg::PADDR_W'(int'(p) * plar_pkg::DIM + int'(jj));
  endfunction

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign last_j   = (j == plar_pkg::J_W'(plar_pkg::DIM - 1));

  always_comb begin
    unique case (state)
      S_APP_RD:  rd_pidx = plar_pkg::PIDX_W'(count - plar_pkg::CNT_W'(1));
      S_I_RDA:   rd_pidx = s;
      S_I_RDB:   rd_pidx = s + plar_pkg::PIDX_W'(1);
      default:   rd_pidx = pidx;
    endcase
    pt_raddr = paddr(rd_pidx, j);
    pt_we    = (state == S_APP_RD);
    pt_waddr = paddr(plar_pkg::PIDX_W'(count), j);
  end

  assign acc_sum      = acc + plar_pkg::ACC_W'(sq);
  assign seg_we       = (state == S_APP_SQRT) && sqrt_done;
  assign sqrt_start   = (state == S_APP_ACC) && last_j && (count != '0);
  assign div_start    = (state == S_I_M2);
  assign div_dividend = {phi, plar_pkg::HALF_W'(0)} + plar_pkg::PROD_W'(plo);

  assign diff     = $signed({pt_rdata[plar_pkg::COORD_W-1], pt_rdata})
                  - $signed({a_val[plar_pkg::COORD_W-1], a_val});
  assign pos_prod = total * frac;
  assign tot_sum  = {1'b0, total} + plar_pkg::LEN_W'(sqrt_root);
  assign q32      = neg ? (plar_pkg::COORD_W'(0) - div_q[plar_pkg::COORD_W-1:0])
                        : div_q[plar_pkg::COORD_W-1:0];

  plar_ram #(.WIDTH(plar_pkg::COORD_W), .DEPTH(plar_pkg::MAX_POINTS * plar_pkg::DIM)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (cin[j]),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  plar_ram #(.WIDTH(plar_pkg::LEN_W), .DEPTH(plar_pkg::MAX_POINTS)) u_seg_ram (
    .clk   (clk),
    .we    (seg_we),
    .waddr (plar_pkg::PIDX_W'(count - plar_pkg::CNT_W'(1))),
    .wdata (plar_pkg::LEN_W'(sqrt_root)),
    .raddr (s),
    .rdata (seg_rdata)
  );

  plar_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand ({1'b0, acc_sum}),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  plar_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (seg_dist),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            for (int k = 0; k < NF; k++) begin
              res[k] <= '0;
            end
            cin[0] <= in_coord_0;
            cin[1] <= in_coord_1;
            cin[2] <= in_coord_2;
            cin[3] <= in_coord_3;
            cin[4] <= in_coord_4;
            cin[5] <= in_coord_5;
            frac   <= fraction[16:0];
            j      <= '0;
            acc    <= '0;
            unique case (plar_pkg::op_t'(opcode))
              plar_pkg::OP_CLEAR: begin
                count      <= '0;
                total      <= '0;
                res_status <= plar_pkg::STATUS_OK;
                state      <= S_DONE;
              end
              plar_pkg::OP_APPEND: begin
                if (count >= plar_pkg::CNT_W'(plar_pkg::MAX_POINTS)) begin
                  res_status <= plar_pkg::STATUS_FULL;
                  state      <= S_DONE;
                end else begin
                  res_status <= plar_pkg::STATUS_OK;
                  state      <= S_APP_RD;
                end
              end
              plar_pkg::OP_QUERY: begin
                priority if (count == '0) begin
                  res_status <= plar_pkg::STATUS_EMPTY;
                  state      <= S_DONE;
                end else if (count == plar_pkg::CNT_W'(1) || fraction < 0) begin
                  res_status <= plar_pkg::STATUS_OK;
                  pidx       <= '0;
                  state      <= S_EMIT_RD;
                end else if (fraction > FRAC_ONE) begin
                  res_status <= plar_pkg::STATUS_OK;
                  pidx       <= plar_pkg::PIDX_W'(count - plar_pkg::CNT_W'(1));
                  state      <= S_EMIT_RD;
                end else begin
                  res_status <= plar_pkg::STATUS_OK;
                  state      <= S_Q_POS;
                end
              end
              plar_pkg::OP_NONE: begin
                res_status <= plar_pkg::STATUS_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_APP_RD: begin
          a_val <= cin[j];
          state <= S_APP_DIFF;
        end
        S_APP_DIFF: begin
          absd  <= diff < 0 ? plar_pkg::COORD_W'(-diff) : plar_pkg::COORD_W'(diff);
          state <= S_APP_SQ;
        end
        S_APP_SQ: begin
          sq    <= absd * absd;
          state <= S_APP_ACC;
        end
        S_APP_ACC: begin
          acc <= acc_sum;
          if (last_j) begin
            state <= (count == '0) ? S_APP_END : S_APP_SQRT;
          end else begin
            j     <= j + plar_pkg::J_W'(1);
            state <= S_APP_RD;
          end
        end
        S_APP_SQRT: begin
          if (sqrt_done) begin
            total <= tot_sum[plar_pkg::LEN_W] ? '1 : tot_sum[plar_pkg::LEN_W-1:0];
            count <= count + plar_pkg::CNT_W'(1);
            state <= S_DONE;
          end
        end
        S_APP_END: begin
          count <= count + plar_pkg::CNT_W'(1);
          state <= S_DONE;
        end
        S_EMIT_RD: state <= S_EMIT_CAP;
        S_EMIT_CAP: begin
          res[j] <= pt_rdata;
          if (last_j) begin
            state <= S_DONE;
          end else begin
            j     <= j + plar_pkg::J_W'(1);
            state <= S_EMIT_RD;
          end
        end
        S_Q_POS: begin
          pos   <= pos_prod[plar_pkg::LEN_W+15:16];
          s     <= '0;
          state <= S_Q_RD;
        end
        S_Q_RD: state <= S_Q_CMP;
        S_Q_CMP: begin
          j <= '0;
          priority if (pos > seg_rdata) begin
            pos <= pos - seg_rdata;
            if (plar_pkg::CNT_W'(s) + plar_pkg::CNT_W'(2) >= count) begin
              pidx  <= plar_pkg::PIDX_W'(count - plar_pkg::CNT_W'(1));
              state <= S_EMIT_RD;
            end else begin
              s     <= s + plar_pkg::PIDX_W'(1);
              state <= S_Q_RD;
            end
          end else if (seg_rdata == '0) begin
            pidx  <= s;
            state <= S_EMIT_RD;
          end else begin
            seg_dist <= seg_rdata;
            state    <= S_I_RDA;
          end
        end
        S_I_RDA: state <= S_I_RDB;
        S_I_RDB: begin
          a_val <= pt_rdata;
          state <= S_I_V;
        end
        S_I_V: begin
          neg   <= diff < 0;
          absd  <= diff < 0 ? plar_pkg::COORD_W'(-diff) : plar_pkg::COORD_W'(diff);
          state <= S_I_M1;
        end
        S_I_M1: begin
          plo   <= pos[plar_pkg::HALF_W-1:0] * absd;
          phi   <= pos[plar_pkg::LEN_W-1:plar_pkg::HALF_W] * absd;
          state <= S_I_M2;
        end
        S_I_M2: state <= S_I_DIV;
        S_I_DIV: begin
          if (div_done) begin
            res[j] <= a_val + q32;
            if (last_j) begin
              state <= S_DONE;
            end else begin
              j     <= j + plar_pkg::J_W'(1);
              state <= S_I_RDA;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            for (int k = 0; k < NF; k++) begin
              oc[k] <= (k < plar_pkg::DIM) ? res[k] : '0;
            end
            status        <= res_status;
            stored_points <= 7'(count);
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_coord_0 = oc[0];
  assign out_coord_1 = oc[1];
  assign out_coord_2 = oc[2];
  assign out_coord_3 = oc[3];
  assign out_coord_4 = oc[4];
  assign out_coord_5 = oc[5];

endmodule

// ===== sv/plar_ram.sv =====
// generic simple dual-port ram with registered read
module plar_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/plar_sqrt.sv =====
// iterative integer square root, two radicand bits per cycle
module plar_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [plar_pkg::RAD_W-1:0]   radicand,
  output logic                         done,
  output logic [plar_pkg::ROOT_W-1:0]  root
);

  localparam int REM_W = plar_pkg::ROOT_W + 4;
  localparam int CNT_W = $clog2(plar_pkg::ROOT_W + 1);

  logic [plar_pkg::RAD_W-1:0] rad;
  logic [REM_W-1:0]           rem;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;
  logic [REM_W-1:0]           t;
  logic [REM_W-1:0]           trial;

  always_comb begin
    t     = {rem[REM_W-3:0], rad[plar_pkg::RAD_W-1 -: 2]};
    trial = REM_W'({root, 2'b01});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= CNT_W'(plar_pkg::ROOT_W);
        busy <= 1'b1;
      end else if (busy) begin
        rad <= {rad[plar_pkg::RAD_W-3:0], 2'b00};
        if (t >= trial) begin
          rem  <= t - trial;
          root <= {root[plar_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= t;
          root <= {root[plar_pkg::ROOT_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/plar_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module plar_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [plar_pkg::PROD_W-1:0] dividend,
  input  logic [plar_pkg::LEN_W-1:0]  divisor,
  output logic                        done,
  output logic [plar_pkg::QUO_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(plar_pkg::QUO_W + 1);

  logic [plar_pkg::LEN_W-1:0] rem;
  logic [plar_pkg::LEN_W-1:0] dvs;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;
  logic [plar_pkg::LEN_W:0]   t;

  always_comb begin
    t = {rem, quotient[plar_pkg::QUO_W-1]};
  end

  // quotient is known to fit, so the top dividend bits start below the divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= plar_pkg::LEN_W'(dividend[plar_pkg::PROD_W-1:plar_pkg::QUO_W]);
        quotient <= dividend[plar_pkg::QUO_W-1:0];
        dvs      <= divisor;
        cnt      <= CNT_W'(plar_pkg::QUO_W);
        busy     <= 1'b1;
      end else if (busy) begin
        if (t >= {1'b0, dvs}) begin
          rem      <= plar_pkg::LEN_W'(t - {1'b0, dvs});
          quotient <= {quotient[plar_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem      <= t[plar_pkg::LEN_W-1:0];
          quotient <= {quotient[plar_pkg::QUO_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
